FILE: rtl/credit_return_batcher_defines.svh
// assertion macros for the credit return batcher checker
// used by crb_checker.sv; expects clk and rst in the scope of use
`ifndef CREDIT_RETURN_BATCHER_DEFINES_SVH
`define CREDIT_RETURN_BATCHER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CRB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define CRB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/crb_pkg.sv
`timescale 1ns / 1ps
// types, codes and constants of the credit return batcher
// no dependencies; used by every module of the block
package crb_pkg;

  localparam int unsigned NUM_CH        = 3;
  localparam int unsigned BATCH_MAX_DEF = 32;

  // item commands
  localparam logic [1:0] CMD_COMPLETE = 2'd0;
  localparam logic [1:0] CMD_FLUSH    = 2'd1;
  localparam logic [1:0] CMD_CLEAR    = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_UPDATE  = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;
  localparam logic [1:0] KIND_ACK     = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BADARG   = 2'd1;
  localparam logic [1:0] ST_BADSTATE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SESSION     = 2'd0;
  localparam logic [1:0] CFG_ENABLE      = 2'd1;
  localparam logic [1:0] CFG_INIT_CREDIT = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] session_tag;
    logic [1:0]  channel_index;
    logic [31:0] units;
    logic        backend_failed;
    logic [2:0]  send_ok_mask;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [1:0]  out_channel;
    logic [31:0] credit_units;
    logic [31:0] failures_drained;
    logic        wake;
    logic        retry;
    logic        last;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic prep;
    logic commit;
    logic flush_start;
    logic scan_step;
    logic summary;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_flush;
    logic out_free;
    logic scan_emit;
    logic scan_last;
  } ctl_stat_t;

endpackage

FILE: rtl/crb_ctrl.sv
`timescale 1ns / 1ps
// sequencing state machine of the credit return batcher
// depends on crb_pkg; drives crb_datapath through ctl_cmd_t
module crb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  crb_pkg::ctl_stat_t  stat,
  output crb_pkg::ctl_cmd_t   cmd,
  output logic                busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_COMMIT,
    S_SCAN,
    S_SUMMARY
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.is_flush) begin
          cmd.flush_start = 1'b1;
          state_next      = S_SCAN;
        end else begin
          cmd.prep   = 1'b1;
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        // hold only when this channel emits and the output is occupied
        if (!stat.scan_emit || stat.out_free) begin
          cmd.scan_step = 1'b1;
          if (stat.scan_last) begin
            state_next = S_SUMMARY;
          end
        end
      end
      S_SUMMARY: begin
        if (stat.out_free) begin
          cmd.summary = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/crb_datapath.sv
`timescale 1ns / 1ps
// counters, configuration registers and output register of the batcher
// depends on crb_pkg; commanded by crb_ctrl
module crb_datapath #(
  parameter int unsigned BATCH_MAX = crb_pkg::BATCH_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  crb_pkg::ctl_cmd_t  cmd,
  output crb_pkg::ctl_stat_t stat,
  input  crb_pkg::item_t     item,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               result_valid,
  input  logic               result_stall,
  output crb_pkg::result_t   result
);

  localparam int unsigned BW        = $clog2(BATCH_MAX + 1);
  localparam logic [31:0] BATCH_M32 = 32'(BATCH_MAX);
  localparam logic [BW-1:0] BATCH_RST = BW'(BATCH_MAX);
  localparam int unsigned CW        = $clog2(crb_pkg::NUM_CH);
  localparam logic [CW-1:0] CH_LAST = CW'(crb_pkg::NUM_CH - 1);

  // configuration
  logic [31:0]   session;
  logic          enabled;
  logic [BW-1:0] batch_size;

  // pending state
  logic [31:0] pend [crb_pkg::NUM_CH];
  logic [31:0] failures;
  logic        wake_q;

  // latched item and per-item working registers
  crb_pkg::item_t it;
  logic [31:0]    sum_reg;
  logic [1:0]     stat_reg;
  logic [31:0]    drained;
  logic           retry;
  logic [CW-1:0]  scan_ch;

  logic [CW-1:0]  ch_sel;
  logic [32:0]    raw_sum;
  logic [1:0]     stat_next;
  logic           wake_hit;
  logic           send_ok;
  logic           out_free;
  logic           load;
  crb_pkg::result_t res_next;

  assign ch_sel   = (it.channel_index < CW'(crb_pkg::NUM_CH)) ? it.channel_index[CW-1:0]
                                                            : '0;
  assign raw_sum  = {1'b0, pend[ch_sel]} + {1'b0, it.units};
  assign wake_hit = !wake_q && (sum_reg >= {{(32 - BW){1'b0}}, batch_size});
  assign send_ok  = (session != '0) && it.send_ok_mask[scan_ch];
  assign out_free = !result_valid || !result_stall;

  always_comb begin
    if (it.units == '0 || it.channel_index >= 2'(crb_pkg::NUM_CH)) begin
      stat_next = crb_pkg::ST_BADARG;
    end else if (!enabled || session == '0 || it.session_tag != session) begin
      stat_next = crb_pkg::ST_BADSTATE;
    end else begin
      stat_next = crb_pkg::ST_OK;
    end
  end

  assign stat.is_flush  = (it.command == crb_pkg::CMD_FLUSH);
  assign stat.out_free  = out_free;
  assign stat.scan_emit = (pend[scan_ch] != '0) && send_ok;
  assign stat.scan_last = (scan_ch == CH_LAST);

  // result assembled for whichever step loads the output
  always_comb begin
    res_next = '0;
    load     = 1'b0;
    if (cmd.commit) begin
      load          = 1'b1;
      res_next.last = 1'b1;
      case (it.command)
        crb_pkg::CMD_COMPLETE: begin
          res_next.kind   = crb_pkg::KIND_STATUS;
          res_next.status = stat_reg;
          res_next.wake   = (stat_reg == crb_pkg::ST_OK) && wake_hit;
        end
        crb_pkg::CMD_CLEAR: begin
          res_next.kind = crb_pkg::KIND_ACK;
        end
        default: begin
          res_next.kind   = crb_pkg::KIND_STATUS;
          res_next.status = crb_pkg::ST_BADARG;
        end
      endcase
    end else if (cmd.scan_step && stat.scan_emit) begin
      load                  = 1'b1;
      res_next.kind         = crb_pkg::KIND_UPDATE;
      res_next.out_channel  = 2'(scan_ch);
      res_next.credit_units = pend[scan_ch];
    end else if (cmd.summary) begin
      load                      = 1'b1;
      res_next.kind             = crb_pkg::KIND_SUMMARY;
      res_next.failures_drained = drained;
      res_next.retry            = retry;
      res_next.last             = 1'b1;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      session    <= '0;
      enabled    <= 1'b0;
      batch_size <= BATCH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        crb_pkg::CFG_SESSION: begin
          session <= cfg_data;
        end
        crb_pkg::CFG_ENABLE: begin
          enabled <= cfg_data[0];
        end
        crb_pkg::CFG_INIT_CREDIT: begin
          if (cfg_data == '0 || cfg_data > BATCH_M32) begin
            batch_size <= BATCH_RST;
          end else begin
            batch_size <= cfg_data[BW-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // item latch and working registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      it <= item;
    end
    if (cmd.prep) begin
      stat_reg <= stat_next;
      sum_reg  <= raw_sum[32] ? '1 : raw_sum[31:0];
    end
    if (cmd.flush_start) begin
      drained <= failures;
      retry   <= 1'b0;
      scan_ch <= '0;
    end
    if (cmd.scan_step) begin
      scan_ch <= scan_ch + CW'(1);
      if (pend[scan_ch] != '0 && !send_ok) begin
        retry <= 1'b1;
      end
    end
  end

  // pending state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < crb_pkg::NUM_CH; i++) begin
        pend[i] <= '0;
      end
      failures <= '0;
      wake_q   <= 1'b0;
    end else begin
      if (cmd.flush_start) begin
        failures <= '0;
        wake_q   <= 1'b0;
      end
      if (cmd.scan_step && stat.scan_emit) begin
        pend[scan_ch] <= '0;
      end
      if (cmd.commit) begin
        if (it.command == crb_pkg::CMD_COMPLETE && stat_reg == crb_pkg::ST_OK) begin
          pend[ch_sel] <= sum_reg;
          if (it.backend_failed && failures != '1) begin
            failures <= failures + 32'd1;
          end
          if (wake_hit) begin
            wake_q <= 1'b1;
          end
        end else if (it.command == crb_pkg::CMD_CLEAR) begin
          for (int i = 0; i < crb_pkg::NUM_CH; i++) begin
            pend[i] <= '0;
          end
          failures <= '0;
          wake_q   <= 1'b0;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= res_next;
    end
  end

endmodule

FILE: rtl/credit_return_batcher.sv
`timescale 1ns / 1ps
// a completion, clear or unknown item is latched, decoded, then committed to the output;
//   a flush is latched, decoded, visits three channels, loads a summary; commit, emitting
//   visits and summary wait on a stalled output; a new item is taken once the last is done;
// the single output register lets the next item in while the last result waits
// reset: synchronous rst clears counts, failure count, wake flag, session, enable and output
//   valid and sets batch size to BATCH_MAX; items and register writes are held off in reset
module credit_return_batcher #(
  parameter int unsigned BATCH_MAX = crb_pkg::BATCH_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst,
  // item channel
  input  logic             item_valid,
  output logic             item_stall,
  input  crb_pkg::item_t   item,
  // result channel
  output logic             result_valid,
  input  logic             result_stall,
  output crb_pkg::result_t result,
  // configuration write channel
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data
);

  crb_pkg::ctl_cmd_t  cmd;
  crb_pkg::ctl_stat_t stat;
  logic               busy;

  // an item is taken only in idle and out of reset; the controller latches it on that edge
  assign item_stall = busy | rst;

  // registers are written only while idle and out of reset
  assign cfg_ready = !busy && !rst;

  // controller: decode, commit, channel scan and summary steps
  crb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy)
  );

  // datapath: pending counters, failure count, wake flag and output register
  crb_datapath #(
    .BATCH_MAX (BATCH_MAX)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .item         (item),
    .cfg_we       (cfg_valid & cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

FILE: rtl/crb_checker.sv
`timescale 1ns / 1ps
// port-level checks on the result channel of the batcher
// depends on crb_pkg and credit_return_batcher_defines.svh; bound to the top level
`include "credit_return_batcher_defines.svh"

module crb_checker (
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic             result_stall,
  input crb_pkg::result_t result
);

  `CRB_ASSERT_NEXT(a_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

  `CRB_ASSERT_NOW(a_update_not_last, result_valid && result.kind == crb_pkg::KIND_UPDATE, !result.last && result.credit_units != '0, "credit update marked last or empty")

  `CRB_ASSERT_NOW(a_summary_last, result_valid && result.kind == crb_pkg::KIND_SUMMARY, result.last && result.status == crb_pkg::ST_OK, "flush summary not final")

  `CRB_ASSERT_NOW(a_wake_ok, result_valid && result.wake, result.kind == crb_pkg::KIND_STATUS && result.status == crb_pkg::ST_OK, "wake on a rejected item")

endmodule

bind credit_return_batcher crb_checker u_crb_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
